[src/lqlm_pkg.sv]
// types, constants and helper functions shared by the line query match scorer
`timescale 1ns / 1ps

package lqlm_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned LEN_W       = 6;
   localparam int unsigned RUN_W       = 6;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned CMP_W       = 8;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 40;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

   localparam logic [BYTE_W-1:0]  NEWLINE_CHAR = 8'h0A;
   localparam logic [BYTE_W-1:0]  ZERO_CHAR    = 8'h00;
   localparam logic [BYTE_W-1:0]  UPPER_FIRST  = 8'h41;
   localparam logic [BYTE_W-1:0]  UPPER_LAST   = 8'h5A;
   localparam logic [BYTE_W-1:0]  CASE_OFFSET  = 8'h20;
   localparam logic [RUN_W-1:0]   RUN_MAX      = 6'd63;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
   localparam logic [LEN_W-1:0]   LEN_RESET    = 6'd1;

   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_TEXT  = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_TEXT,
      OP_NEWLINE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   char_value;
      logic                char_ok;
      logic [POS_W-1:0]    position;
   } item_type;

   typedef struct packed {
      logic                step;
      logic                clear;
      logic [BYTE_W-1:0]   text_char;
      logic                text_ok;
   } cell_ctrl_type;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] folded;
      folded = c;
      if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
         folded = c + CASE_OFFSET;
      end
      return folded;
   endfunction

   function automatic logic is_matchable(input logic [BYTE_W-1:0] c);
      return (c != ZERO_CHAR) && (c != NEWLINE_CHAR);
   endfunction

endpackage

[src/lqlm_front.sv]
// front end: takes requests, folds case and sorts them into load, text and newline
`timescale 1ns / 1ps

module lqlm_front
   import lqlm_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  queue_full,
   output logic                  push,
   output item_type              push_item
);

   logic [BYTE_W-1:0] req_byte;

   assign req_byte   = req_tdata[BYTE_W-1:0];
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_item.char_value = fold_case(req_byte);
      push_item.char_ok    = is_matchable(req_byte);
      push_item.position   = req_tdata[BYTE_W +: POS_W];
      if (req_tuser == KIND_QUERY) begin
         push_item.op = OP_LOAD;
      end else if (req_byte == NEWLINE_CHAR) begin
         push_item.op = OP_NEWLINE;
      end else begin
         push_item.op = OP_TEXT;
      end
   end

endmodule

[src/lqlm_fifo.sv]
// short request queue between front end and back end
`timescale 1ns / 1ps

module lqlm_fifo
   import lqlm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     not_empty
);

   localparam logic [QUEUE_IDX_W:0] DEPTH_COUNT = (QUEUE_IDX_W + 1)'(QUEUE_DEPTH);

   item_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]  wr_ptr_ff;
   logic [QUEUE_IDX_W-1:0]  wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]  rd_ptr_ff;
   logic [QUEUE_IDX_W-1:0]  rd_ptr_in;
   logic [QUEUE_IDX_W:0]    count_ff;
   logic [QUEUE_IDX_W:0]    count_in;

   assign full      = (count_ff == DEPTH_COUNT);
   assign not_empty = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("queue read while empty");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT) else $error("queue count beyond depth");

endmodule

[src/lqlm_cell.sv]
// one query position: stored character and the run ending at it
`timescale 1ns / 1ps

module lqlm_cell
   import lqlm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic              load_en,
   input  logic [BYTE_W-1:0] load_char,
   input  logic              load_ok,
   input  logic              enable,
   input  logic [RUN_W-1:0]  prev_run,
   input  logic [RUN_W:0]    best_plus,
   output logic [RUN_W-1:0]  run,
   output logic              grow
);

   logic [BYTE_W-1:0] query_char_ff;
   logic              query_ok_ff;
   logic [RUN_W-1:0]  run_ff;
   logic [RUN_W-1:0]  run_in;
   logic [RUN_W-1:0]  next_run;
   logic              hit;

   always_comb begin
      hit = enable && ctrl.text_ok && query_ok_ff && (ctrl.text_char == query_char_ff);
      if (!hit) begin
         next_run = '0;
      end else if (prev_run == RUN_MAX) begin
         next_run = RUN_MAX;
      end else begin
         next_run = prev_run + 1'b1;
      end
      if (ctrl.clear) begin
         run_in = '0;
      end else if (ctrl.step) begin
         run_in = next_run;
      end else begin
         run_in = run_ff;
      end
      grow = ctrl.step && ({1'b0, next_run} == best_plus);
   end

   assign run = run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         query_char_ff <= load_char;
         query_ok_ff   <= load_ok;
      end
   end

endmodule

[src/lqlm_back.sv]
// back end: comparison cells, running best, counters and result register
`timescale 1ns / 1ps

module lqlm_back
   import lqlm_pkg::*;
#(
   parameter int unsigned QUERY_MAX = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [LEN_W-1:0]      csr_wr_data,
   input  logic                  not_empty,
   input  item_type              pop_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [LEN_W-1:0]   query_length_ff;
   logic [RUN_W-1:0]   best_ff;
   logic [RUN_W-1:0]   best_in;
   logic [COUNT_W-1:0] line_cnt_ff;
   logic [COUNT_W-1:0] line_cnt_in;
   logic [COUNT_W-1:0] byte_cnt_ff;
   logic [COUNT_W-1:0] byte_cnt_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [COUNT_W-1:0] line_out_ff;
   logic [COUNT_W-1:0] bytes_out_ff;
   logic [RUN_W-1:0]   score_out_ff;

   cell_ctrl_type      ctrl;
   logic               do_load;
   logic [RUN_W:0]     best_plus;
   logic [RUN_W-1:0]   runs [QUERY_MAX];
   logic [QUERY_MAX-1:0] grow_vec;

   always_comb begin
      pop = not_empty && ((pop_item.op != OP_NEWLINE) || !rsp_valid_ff || rsp_tready);
      do_load        = pop && (pop_item.op == OP_LOAD);
      ctrl.step      = pop && (pop_item.op == OP_TEXT);
      ctrl.clear     = pop && (pop_item.op == OP_NEWLINE);
      ctrl.text_char = pop_item.char_value;
      ctrl.text_ok   = pop_item.char_ok;
      best_plus      = {1'b0, best_ff} + 1'b1;
   end

   for (genvar q = 0; q < QUERY_MAX; q++) begin : g_cell
      localparam logic [CMP_W-1:0] CELL_POS = CMP_W'(q);
      logic [RUN_W-1:0] prev_run;
      logic             cell_enable;
      logic             load_sel;

      if (q == 0) begin : g_first
         assign prev_run = '0;
      end else begin : g_rest
         assign prev_run = runs[q-1];
      end

      assign cell_enable = {{(CMP_W - LEN_W){1'b0}}, query_length_ff} > CELL_POS;
      assign load_sel    = do_load &&
                           ({{(CMP_W - POS_W){1'b0}}, pop_item.position} == CELL_POS);

      lqlm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_en   (load_sel),
         .load_char (pop_item.char_value),
         .load_ok   (pop_item.char_ok),
         .enable    (cell_enable),
         .prev_run  (prev_run),
         .best_plus (best_plus),
         .run       (runs[q]),
         .grow      (grow_vec[q])
      );
   end

   // a new run can pass the best by at most one
   always_comb begin
      best_in     = best_ff;
      line_cnt_in = line_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      if (ctrl.clear) begin
         best_in     = '0;
         byte_cnt_in = '0;
         if (line_cnt_ff != COUNT_MAX) begin
            line_cnt_in = line_cnt_ff + 1'b1;
         end
      end else if (ctrl.step) begin
         if (|grow_vec) begin
            best_in = best_ff + 1'b1;
         end
         if (byte_cnt_ff != COUNT_MAX) begin
            byte_cnt_in = byte_cnt_ff + 1'b1;
         end
      end
      if (ctrl.clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_length_ff <= LEN_RESET;
         best_ff         <= '0;
         line_cnt_ff     <= COUNT_W'(1);
         byte_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            query_length_ff <= csr_wr_data;
         end
         best_ff      <= best_in;
         line_cnt_ff  <= line_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         line_out_ff  <= line_cnt_ff;
         bytes_out_ff <= byte_cnt_ff;
         score_out_ff <= best_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2 * COUNT_W - RUN_W){1'b0}},
                        score_out_ff, bytes_out_ff, line_out_ff};

   a_best_cleared_after_line: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> best_ff == '0) else $error("best not cleared after newline");

   a_best_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> ({1'b0, best_ff} <= {1'b0, $past(best_ff)} + 1'b1))
      else $error("best grew by more than one");

   a_line_counter_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_cnt_ff != '0) else $error("line counter reached zero");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !ctrl.clear)
      else $error("pending result overwritten");

endmodule

[src/line_query_longest_match_score.sv]
// top level of the line scorer by longest case-insensitive run shared with a stored query
//
//   channel   dir   handshake                 payload
//   req       in    req_tvalid / req_tready   tuser: kind; tdata: byte_value, query_position
//   rsp       out   rsp_tvalid / rsp_tready   tdata: line_number, line_bytes, match_score
//   csr       in    csr_wr_en                 csr_wr_data: query_length
//
// one request per cycle unless the queue is full; it holds two requests between front and back
// a text byte updates the comparison cells at the edge it leaves the queue
// a result shows at the edge its newline leaves the queue
// a newline at the head of the queue waits only while an earlier result is still held in rsp
// reset needs no clearing pass; the query store keeps no reset
`timescale 1ns / 1ps

module line_query_longest_match_score
   import lqlm_pkg::*;
#(
   parameter int unsigned QUERY_MAX = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // byte_value, query_position, zero fill
   input  logic                  req_tuser,   // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // line_number, line_bytes, match_score, zero fill
   input  logic                  csr_wr_en,
   input  logic [LEN_W-1:0]      csr_wr_data
);

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     pop;
   item_type pop_item;
   logic     not_empty;

   lqlm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   lqlm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (not_empty)
   );

   lqlm_back #(
      .QUERY_MAX (QUERY_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .not_empty   (not_empty),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
